/* rtl/core/mtg_pkg.sv */
// ----------------------------------------------------------------------------
// mtg_pkg
// Types, constants and word functions shared by the generator core and
// its output queue.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int unsigned C_STATE_DEPTH  = 624;
    localparam int unsigned C_TWIST_OFFSET = 397;
    localparam int unsigned C_ADDR_W       = $clog2(C_STATE_DEPTH);
    localparam int unsigned C_INDEX_W      = 10;
    localparam int unsigned C_WORD_W       = 32;
    localparam int unsigned C_OUT_DEPTH    = 3;
    localparam int unsigned C_OUT_PTR_W    = $clog2(C_OUT_DEPTH);
    localparam int unsigned C_OUT_CNT_W    = $clog2(C_OUT_DEPTH + 1);

    typedef logic [C_ADDR_W-1:0]    t_addr;
    typedef logic [C_INDEX_W-1:0]   t_index;
    typedef logic [C_WORD_W-1:0]    t_word;
    typedef logic [C_OUT_PTR_W-1:0] t_out_ptr;
    typedef logic [C_OUT_CNT_W-1:0] t_out_cnt;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_DRAW = 1'b1
    } t_action;

    localparam t_addr  C_LAST_ADDR  = t_addr'(C_STATE_DEPTH - 1);
    localparam t_addr  C_FAR_WRAP   = t_addr'(C_STATE_DEPTH - C_TWIST_OFFSET);
    localparam t_addr  C_FAR_ADD    = t_addr'(C_TWIST_OFFSET);
    localparam t_index C_INDEX_LIM  = t_index'(C_STATE_DEPTH);

    localparam t_word C_TWIST_MAGIC = 32'h9908_b0df;
    localparam t_word C_UPPER_MASK  = 32'h8000_0000;
    localparam t_word C_LOWER_MASK  = 32'h7fff_ffff;
    localparam t_word C_TEMPER_B    = 32'h9d2c_5680;
    localparam t_word C_TEMPER_C    = 32'hefc6_0000;
    localparam int unsigned C_TEMPER_U = 11;
    localparam int unsigned C_TEMPER_S = 7;
    localparam int unsigned C_TEMPER_T = 15;
    localparam int unsigned C_TEMPER_L = 18;

    function automatic t_word f_twist(input t_word cur, input t_word nxt, input t_word far);
        t_word y;
        y = (cur & C_UPPER_MASK) | (nxt & C_LOWER_MASK);
        return far ^ (y >> 1) ^ (y[0] ? C_TWIST_MAGIC : '0);
    endfunction

    function automatic t_word f_temper(input t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> C_TEMPER_U);
        y = y ^ ((y << C_TEMPER_S) & C_TEMPER_B);
        y = y ^ ((y << C_TEMPER_T) & C_TEMPER_C);
        y = y ^ (y >> C_TEMPER_L);
        return y;
    endfunction

endpackage

/* rtl/core/mtg_ram.sv */
// ----------------------------------------------------------------------------
// mtg_ram
// Generic single-write, single-read RAM with a registered read. A read of the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module mtg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/mtg_ofifo.sv */
// ----------------------------------------------------------------------------
// mtg_ofifo
// Small output queue that holds finished words until the receiver takes
// them, so the core keeps running while the output side stalls until it fills.
// ----------------------------------------------------------------------------
module mtg_ofifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtg_pkg::t_word    i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output mtg_pkg::t_word    o_data,
    output mtg_pkg::t_out_cnt o_count
);
    import mtg_pkg::*;

    t_word    r_mem [C_OUT_DEPTH];
    t_out_ptr r_wr_ptr, n_wr_ptr;
    t_out_ptr r_rd_ptr, n_rd_ptr;
    t_out_cnt r_count, n_count;
    logic     s_pop;

    function automatic t_out_ptr f_inc(input t_out_ptr p);
        return (p == t_out_ptr'(C_OUT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign s_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? f_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = s_pop  ? f_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !s_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && s_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/core/mersenne_twister_generator_unit.sv */
// ----------------------------------------------------------------------------
// mersenne_twister_generator_unit
// MT19937 generator with the twist done one state word per draw.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready): each word is a load (i_action = 0) that
// writes i_word_value to state word i_word_index and rewinds the read
// position, or a draw (i_action = 1) that yields one tempered 32-bit word.
// An index of 624 or more writes nothing but still rewinds the position.
// Output channel (o_valid / i_ready): one o_random_value per draw, in order.
// Throughput: one word per cycle, loads and draws mixed freely. The state
// sits in two copies of a 624 x 32 RAM, one read port each, fed word i+1
// and word i+397; word i is carried over from the previous draw in a
// register. A draw goes through the registered RAM read, the twist and
// temper, and the output queue. Reset: a clearing pass writes zero to all
// 624 words, one per cycle; o_ready stays low until the pass ends. When the
// receiver stalls, results collect in the output queue; once three are
// queued or in flight, o_ready drops.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_action,
    input  mtg_pkg::t_index i_word_index,
    input  mtg_pkg::t_word  i_word_value,
    output logic            o_valid,
    input  logic            i_ready,
    output mtg_pkg::t_word  o_random_value
);
    import mtg_pkg::*;

    logic     s_accept;
    t_addr    s_pos_next;
    t_addr    s_pos_far;
    t_addr    s_raddr_a;
    t_addr    s_raddr_b;
    logic     s_load_ok;
    logic     s_we;
    t_addr    s_waddr;
    t_word    s_wdata;
    t_word    s_rd_a;
    t_word    s_rd_b;
    t_word    s_da;
    t_word    s_db;
    t_word    s_twisted;
    logic     s_push;
    t_word    s_result;
    t_out_cnt s_out_count;
    logic     s_out_valid;
    logic [C_OUT_CNT_W:0] s_occ;

    logic  r_clr_active, n_clr_active;
    t_addr r_clr_addr, n_clr_addr;
    t_addr r_pos, n_pos;
    t_word r_cur, n_cur;
    logic  r_s1_valid, r_s1_draw, r_s1_load_ok;
    t_addr r_s1_addr;
    t_word r_s1_value;
    logic  r_fwd_a, r_fwd_b;
    t_word r_fwd_data;

    assign s_occ    = {1'b0, s_out_count} + {{C_OUT_CNT_W{1'b0}}, (r_s1_valid && r_s1_draw)};
    assign o_ready  = !r_clr_active && (s_occ < (C_OUT_CNT_W + 1)'(C_OUT_DEPTH));
    assign s_accept = i_valid && o_ready;

    assign s_pos_next = (r_pos == C_LAST_ADDR) ? '0 : r_pos + 1'b1;
    assign s_pos_far  = (r_pos >= C_FAR_WRAP) ? r_pos - C_FAR_WRAP : r_pos + C_FAR_ADD;
    assign s_raddr_a  = (t_action'(i_action) == ACT_DRAW) ? s_pos_next : '0;
    assign s_raddr_b  = s_pos_far;
    assign s_load_ok  = (i_word_index < C_INDEX_LIM);

    assign s_da      = r_fwd_a ? r_fwd_data : s_rd_a;
    assign s_db      = r_fwd_b ? r_fwd_data : s_rd_b;
    assign s_twisted = f_twist(r_cur, s_da, s_db);
    assign s_result  = f_temper(s_twisted);
    assign s_push    = r_s1_valid && r_s1_draw;

    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_s1_addr;
        s_wdata = r_s1_value;
        n_cur   = r_cur;
        if (r_clr_active) begin
            s_we    = 1'b1;
            s_waddr = r_clr_addr;
            s_wdata = '0;
        end else if (r_s1_valid) begin
            if (r_s1_draw) begin
                s_we    = 1'b1;
                s_wdata = s_twisted;
                n_cur   = s_da;
            end else begin
                s_we  = r_s1_load_ok;
                n_cur = (r_s1_load_ok && (r_s1_addr == '0)) ? r_s1_value : s_da;
            end
        end
    end

    always_comb begin
        n_clr_active = r_clr_active;
        n_clr_addr   = r_clr_addr;
        if (r_clr_active) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == C_LAST_ADDR) begin
                n_clr_active = 1'b0;
            end
        end
        n_pos = r_pos;
        if (s_accept) begin
            n_pos = (t_action'(i_action) == ACT_DRAW) ? s_pos_next : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_pos        <= '0;
            r_cur        <= '0;
            r_s1_valid   <= 1'b0;
            r_fwd_a      <= 1'b0;
            r_fwd_b      <= 1'b0;
        end else begin
            r_clr_active <= n_clr_active;
            r_clr_addr   <= n_clr_addr;
            r_pos        <= n_pos;
            r_cur        <= n_cur;
            r_s1_valid   <= s_accept;
            r_fwd_a      <= s_we && (s_waddr == s_raddr_a);
            r_fwd_b      <= s_we && (s_waddr == s_raddr_b);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_draw    <= (t_action'(i_action) == ACT_DRAW);
        r_s1_load_ok <= s_load_ok;
        r_s1_addr    <= (t_action'(i_action) == ACT_DRAW) ? r_pos : t_addr'(i_word_index);
        r_s1_value   <= i_word_value;
        r_fwd_data   <= s_wdata;
    end

    mtg_ram #(
        .WIDTH (C_WORD_W),
        .DEPTH (C_STATE_DEPTH)
    ) u_ram_nxt (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr_a),
        .o_rdata (s_rd_a)
    );

    mtg_ram #(
        .WIDTH (C_WORD_W),
        .DEPTH (C_STATE_DEPTH)
    ) u_ram_far (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr_b),
        .o_rdata (s_rd_b)
    );

    mtg_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_result),
        .i_pop   (i_ready),
        .o_valid (s_out_valid),
        .o_data  (o_random_value),
        .o_count (s_out_count)
    );

    assign o_valid = s_out_valid;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !o_ready)
        else $error("word accepted during clearing pass");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= C_LAST_ADDR)
        else $error("read position out of range");

    a_load_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !i_action) |=> (r_pos == '0))
        else $error("load did not rewind read position");

    a_draw_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_action) |=> (r_s1_valid && r_s1_draw) ##1 s_out_valid)
        else $error("draw result lost on its way to the output");

    a_no_stage_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !r_s1_valid)
        else $error("write port shared between clearing pass and a word");

endmodule

/* dv/tb_mersenne_twister_generator_unit.sv */
// ----------------------------------------------------------------------------
// tb_mersenne_twister_generator_unit
// Drives load and draw words into the generator and compares every tempered
// output word with a lazy-twist MT19937 predictor kept inside the bench.
// The sender works in random bursts, the receiver stalls on shifting patterns
// and twice holds off long enough to back the block up. Stimulus covers the
// all-zero state, out-of-range loads, extreme values and draw runs that wrap
// past the full 624-word state.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mtg_pkg::*;

    localparam int unsigned DEPTH      = C_STATE_DEPTH;
    localparam int unsigned FAR_STEP   = 397;
    localparam t_word       MAGIC      = 32'h9908_b0df;
    localparam t_word       HIGH_BIT   = 32'h8000_0000;
    localparam t_word       LOW_BITS   = 32'h7fff_ffff;
    localparam t_word       TEMPER_B   = 32'h9d2c_5680;
    localparam t_word       TEMPER_C   = 32'hefc6_0000;
    localparam int unsigned LONG_RUN   = 700;
    localparam int unsigned RAND_ITEMS = 1650;

    typedef struct packed {
        t_action act;
        t_index  idx;
        t_word   val;
    } t_cmd;

    logic   i_clk        = 1'b0;
    logic   i_rst_n      = 1'b0;
    logic   i_valid      = 1'b0;
    logic   i_action     = 1'b0;
    t_index i_word_index = '0;
    t_word  i_word_value = '0;
    logic   i_ready      = 1'b0;
    logic   o_ready;
    logic   o_valid;
    t_word  o_random_value;

    t_cmd    pending_words[$];
    t_word   expected_draws[$];
    t_word   model_words [DEPTH];
    int unsigned mt_pos = 0;

    t_cmd next_cmd;
    int burst_left = 1;
    int gap_left   = 0;
    int rx_cycle   = 0;
    int rx_mode    = 0;
    int hold_left  = 0;

    int fail_count    = 0;
    int loads_seen    = 0;
    int loads_outside = 0;
    int draws_sent    = 0;
    int draws_seen    = 0;
    int draw_run      = 0;
    int longest_run   = 0;

    mersenne_twister_generator_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_word_index   (i_word_index),
        .i_word_value   (i_word_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_value (o_random_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_word temper_word(input t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic void apply_word(input logic act, input t_index idx, input t_word val);
        t_word mix;
        t_word fresh;
        int unsigned p;
        if (act == ACT_LOAD) begin
            if (idx < DEPTH) begin
                model_words[idx] = val;
            end else begin
                loads_outside++;
            end
            mt_pos = 0;
            loads_seen++;
            draw_run = 0;
        end else begin
            p = mt_pos;
            mix = (model_words[p] & HIGH_BIT) | (model_words[(p + 1) % DEPTH] & LOW_BITS);
            fresh = model_words[(p + FAR_STEP) % DEPTH] ^ (mix >> 1) ^ (mix[0] ? MAGIC : '0);
            model_words[p] = fresh;
            expected_draws.push_back(temper_word(fresh));
            mt_pos = (p + 1) % DEPTH;
            draws_sent++;
            draw_run++;
            if (draw_run > longest_run) begin
                longest_run = draw_run;
            end
        end
    endfunction

    task automatic push_load(input t_index idx, input t_word val);
        t_cmd c;
        c.act = ACT_LOAD;
        c.idx = idx;
        c.val = val;
        pending_words.push_back(c);
    endtask

    task automatic push_draws(input int n);
        t_cmd c;
        for (int k = 0; k < n; k++) begin
            c.act = ACT_DRAW;
            c.idx = t_index'($urandom_range(0, 1023));
            c.val = $urandom;
            pending_words.push_back(c);
        end
    endtask

    task automatic push_random_loads(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                push_load(t_index'($urandom_range(624, 1023)), $urandom);
            end else begin
                push_load(t_index'($urandom_range(0, 623)), $urandom);
            end
        end
    endtask

    task automatic build_stimulus();
        t_cmd c;
        int kind;
        int base;
        int n;
        // all-zero state first
        push_draws(3);
        push_load(10'd0, 32'hffff_ffff);
        push_load(10'd623, 32'h0000_0000);
        push_load(10'd1, 32'h0000_0001);
        push_load(10'd396, 32'h8000_0000);
        push_load(10'd397, 32'h7fff_ffff);
        push_load(10'd624, 32'hdead_beef);
        push_load(10'd1023, 32'hffff_ffff);
        push_draws(4);
        push_load(10'd512, 32'haaaa_aaaa);
        push_load(10'd2, 32'h5555_5555);
        push_draws(3);
        push_load(10'd700, 32'h1234_5678);
        push_draws(2);
        base = pending_words.size();

        push_random_loads(40);
        push_draws(LONG_RUN);
        while (pending_words.size() - base < RAND_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                push_random_loads($urandom_range(1, 6));
                push_draws($urandom_range(1, 60));
            end else if (kind == 6) begin
                n = $urandom_range(16, 80);
                for (int k = 0; k < n; k++) begin
                    push_load(t_index'(($urandom_range(0, 623) + k) % DEPTH), $urandom);
                end
                push_draws($urandom_range(1, 30));
            end else if (kind == 7) begin
                n = $urandom_range(1, 10);
                for (int k = 0; k < n; k++) begin
                    c.act = t_action'($urandom_range(0, 1));
                    c.idx = t_index'($urandom_range(0, 1023));
                    c.val = $urandom;
                    pending_words.push_back(c);
                end
            end else if (kind == 8) begin
                push_draws($urandom_range(1, 30));
            end else begin
                push_random_loads($urandom_range(1, 4));
                push_load(t_index'($urandom_range(624, 1023)), $urandom);
                push_draws($urandom_range(1, 20));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                apply_word(i_action, i_word_index, i_word_value);
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    next_cmd = pending_words.pop_front();
                    i_valid      <= 1'b1;
                    i_action     <= next_cmd.act;
                    i_word_index <= next_cmd.idx;
                    i_word_value <= next_cmd.val;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0) begin
                rx_mode <= $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else if (rx_cycle == 1200 || rx_cycle == 3000) begin
                hold_left <= 300;
                i_ready   <= 1'b0;
            end else begin
                case (rx_mode)
                    0: begin
                        i_ready <= 1'b1;
                    end
                    1: begin
                        i_ready <= $urandom_range(0, 1);
                    end
                    2: begin
                        i_ready <= (rx_cycle % 4 != 0);
                    end
                    default: begin
                        i_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            draws_seen++;
            if (expected_draws.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected word, expected none, actual %08h",
                         $time, o_random_value);
            end else if (o_random_value !== expected_draws[0]) begin
                fail_count++;
                $display("%0t: random_value mismatch, expected %08h, actual %08h",
                         $time, expected_draws[0], o_random_value);
                void'(expected_draws.pop_front());
            end else begin
                void'(expected_draws.pop_front());
            end
        end
    end

    initial begin
        foreach (model_words[k]) begin
            model_words[k] = '0;
        end
        build_stimulus();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_words.size() > 0 || i_valid || expected_draws.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
        $display("Run covered %0d loads (%0d outside the state), %0d draws sent, %0d checked,",
                 loads_seen, loads_outside, draws_sent, draws_seen);
        $display("longest uninterrupted draw run %0d words.", longest_run);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
